/* design/lru_key_value_cache_macros.svh */
// Assertion macros shared by the lru_key_value_cache checker.
// No dependencies; include with the bare file name.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define LKV_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is low
`define LKV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/lkv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkv_cell, lru_key_value_cache and lkv_checker.
package lkv_pkg;

    localparam int ENTRIES  = 16;   // number of cells in the recency chain
    localparam int KEY_BITS = 32;   // key bits that take part in the compare (8..32)
    localparam int KEY_W    = 32;   // key port width
    localparam int VALUE_W  = 32;
    localparam int CAP_W    = 5;
    localparam int IDX_W    = $clog2(ENTRIES);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef logic [KEY_BITS-1:0]       t_key;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [IDX_W-1:0]          t_idx;

    // contents handed from one cell to the next (toward the LRU end)
    typedef struct packed {
        logic   valid;
        t_key   key;
        t_value value;
    } t_link;

    // lookup chain running alongside the cells
    typedef struct packed {
        logic   match;   // key found in this cell or a more recent one
        t_value found;   // value of the matching cell
    } t_scan;

    // command broadcast to every cell during the execute cycle
    typedef struct packed {
        logic exec;
        logic put;
        logic hit;
        logic evict;
        t_key key;
    } t_ctl;

endpackage

/* design/lkv_cell.sv */
// One entry of the recency chain: holds valid, key and value, compares the
// broadcast key and loads its neighbor's contents on a shift. Uses lkv_pkg.
module lkv_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lkv_pkg::t_ctl  i_ctl,
    input  lkv_pkg::t_link i_prev,
    input  lkv_pkg::t_scan i_scan,
    output lkv_pkg::t_link o_link,
    output lkv_pkg::t_scan o_scan
);
    import lkv_pkg::*;

    logic   r_valid;
    t_key   r_key;
    t_value r_value;
    logic   n_valid;
    t_key   n_key;
    t_value n_value;
    logic   w_match;
    logic   w_shift;

    // key compare and lookup chain
    assign w_match       = r_valid && (r_key == i_ctl.key);
    assign o_scan.match  = i_scan.match | w_match;
    assign o_scan.found  = (w_match && !i_scan.match) ? r_value : i_scan.found;

    // Shift rule: a hit moves every cell up to the matching one; an insert
    // moves every filled cell, or only up to the last one when evicting.
    always_comb begin
        if (!i_ctl.exec) begin
            w_shift = 1'b0;
        end else if (i_ctl.hit) begin
            w_shift = !i_scan.match;
        end else if (i_ctl.put) begin
            w_shift = i_ctl.evict ? r_valid : i_prev.valid;
        end else begin
            w_shift = 1'b0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        if (w_shift) begin
            n_valid = i_prev.valid;
            n_key   = i_prev.key;
            n_value = i_prev.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: no reset, only read while valid
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.key   = r_key;
    assign o_link.value = r_value;

endmodule

/* design/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: request latch, capacity register,
// chain of lkv_cell entries and result register. Uses lkv_pkg and lkv_cell.
//
//  channel   handshake            payload
//  request   start / busy         i_req_type, i_key, i_write_value
//  result    o_strobe (1 cycle)   o_hit, o_read_value
//  config    i_cfg_we             i_cfg_data (capacity)
//
// The accept edge latches the request and raises busy; during the execute
// cycle, compare, priority chain and shift run across all cells at once.
// busy is high for that execute cycle, and no new request is taken while
// it is high. A get's result is on the ports the cycle after execute.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// The receiver cannot stall; results are never held.
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [lkv_pkg::KEY_W-1:0]     i_key,
    input  logic signed [lkv_pkg::VALUE_W-1:0] i_write_value,
    input  logic                          i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic                          o_hit,
    output logic signed [lkv_pkg::VALUE_W-1:0] o_read_value
);
    import lkv_pkg::*;

    logic             r_busy;
    logic             r_put;
    t_key             r_key;
    t_value           r_wval;
    logic [CAP_W-1:0] r_cap;
    t_idx             w_cap_last;
    logic             w_accept;
    t_ctl             w_ctl;
    t_link            w_link [0:ENTRIES];
    t_scan            w_scan [0:ENTRIES];
    logic [ENTRIES-1:0] w_valid;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // request latch and execute flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_put  <= (i_req_type == REQ_PUT);
            r_key  <= i_key[KEY_BITS-1:0];
            r_wval <= i_write_value;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // last slot in use under the clamped capacity (zero means one entry)
    always_comb begin
        if (r_cap == '0) begin
            w_cap_last = '0;
        end else if (int'(r_cap) > ENTRIES) begin
            w_cap_last = IDX_W'(ENTRIES - 1);
        end else begin
            w_cap_last = IDX_W'(r_cap - CAP_W'(1));
        end
    end

    // valid slots are contiguous from the front, so full means that slot is valid
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            w_valid[j] = w_link[j+1].valid;
        end
    end

    assign w_ctl.exec  = r_busy;
    assign w_ctl.put   = r_put;
    assign w_ctl.hit   = w_scan[ENTRIES].match;
    assign w_ctl.evict = w_valid[w_cap_last];
    assign w_ctl.key   = r_key;

    // new most-recent entry feeds the head of the chain
    assign w_link[0].valid = 1'b1;
    assign w_link[0].key   = r_key;
    assign w_link[0].value = r_put ? r_wval : w_scan[ENTRIES].found;

    assign w_scan[0].match = 1'b0;
    assign w_scan[0].found = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_link[g]),
            .i_scan  (w_scan[g]),
            .o_link  (w_link[g+1]),
            .o_scan  (w_scan[g+1])
        );
    end

    // result register: one strobe per get
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_busy && !r_put;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !r_put) begin
            o_hit        <= w_scan[ENTRIES].match;
            o_read_value <= w_scan[ENTRIES].match ? w_scan[ENTRIES].found : '1;
        end
    end

endmodule

/* design/lkv_checker.sv */
// Port-level checker for lru_key_value_cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_req_type,
    input logic                          o_strobe,
    input logic                          o_hit,
    input logic signed [lkv_pkg::VALUE_W-1:0] o_read_value
);
    import lkv_pkg::*;

    // every accepted get transaction yields a result, registered through busy and then o_strobe
    `LKV_ASSERT_IMPLIES(a_get_gives_result, i_clk, i_rst_n, start && !busy && i_req_type == REQ_GET, ##2 o_strobe)

    // no result appears unless a get was accepted and has passed through its execute cycle
    `LKV_ASSERT_IMPLIES(a_result_has_get, i_clk, i_rst_n, o_strobe, $past(start && !busy && i_req_type == REQ_GET, 2))

    // busy lasts exactly the execute cycle after an accepted transaction
    `LKV_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy)

    // a miss reports all ones
    `LKV_ASSERT_IMPLIES(a_miss_all_ones, i_clk, i_rst_n, o_strobe && !o_hit, o_read_value == -32'sd1)

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_strobe     (o_strobe),
    .o_hit        (o_hit),
    .o_read_value (o_read_value)
);
